/* hdl/ffhp_pkg.sv */
// types and constants for the first-fragment header parser
`timescale 1ns / 1ps
package ffhp_pkg;

   typedef enum logic [2:0] {
      PH_FLAG    = 3'd0,
      PH_TUNNEL  = 3'd1,
      PH_HASH    = 3'd2,
      PH_MSGID   = 3'd3,
      PH_SIZE    = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   localparam logic [2:0] ROLE_FLAG    = 3'd0;
   localparam logic [2:0] ROLE_TUNNEL  = 3'd1;
   localparam logic [2:0] ROLE_HASH    = 3'd2;
   localparam logic [2:0] ROLE_MSGID   = 3'd3;
   localparam logic [2:0] ROLE_SIZE    = 3'd4;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

   localparam logic [1:0] MODE_LOCAL  = 2'd0;
   localparam logic [1:0] MODE_TUNNEL = 2'd1;
   localparam logic [1:0] MODE_ROUTER = 2'd2;
   localparam logic [1:0] MODE_BAD    = 2'd3;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MODE      = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;

   localparam int unsigned IDENT_BYTES = 4;
   localparam int unsigned SIZE_BYTES  = 2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  byte_value;
      logic [4:0]  field_offset;
      logic [1:0]  delivery_mode;
      logic        is_fragmented;
      logic [31:0] tunnel_ident;
      logic [31:0] message_ident;
      logic [15:0] payload_length;
      logic        header_done;
      logic        record_done;
      logic [1:0]  error_code;
   } rsp_word_type;

endpackage

/* hdl/ffhp_if.sv */
// valid/ready channel interfaces for byte input and tagged result words
`timescale 1ns / 1ps
interface ffhp_req_if import ffhp_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ffhp_rsp_if import ffhp_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/first_fragment_header_parser.sv */
// first-fragment record parser: tags each stream byte with its header role
// each accepted byte's result word is registered and appears on rsp_chan in the cycle after it is taken
// throughput: 1 byte per cycle unless rsp_chan stalls; the parse state updates in the same cycle a byte is taken
// a full result register keeps taking bytes while rsp_chan.ready is high
// reset (synchronous): parser expects a flag byte, all assembled fields clear,
// no result word pending
`timescale 1ns / 1ps
module first_fragment_header_parser import ffhp_pkg::*; #(
   parameter int unsigned HASH_BYTES = 32
) (
   input logic        clock,
   input logic        reset,
   ffhp_req_if.sink   req_chan,
   ffhp_rsp_if.source rsp_chan
);

   localparam logic [16:0] HashCount  = 17'(HASH_BYTES);
   localparam logic [16:0] IdentCount = 17'(IDENT_BYTES);
   localparam logic [16:0] SizeCount  = 17'(SIZE_BYTES);

   phase_type    phase_ff, phase_in;
   logic [15:0]  count_ff, count_in;
   logic [1:0]   mode_ff, mode_in;
   logic         frag_ff, frag_in;
   logic [31:0]  tunnel_ff, tunnel_in;
   logic [31:0]  msgid_ff, msgid_in;
   logic [15:0]  size_ff, size_in;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff, rsp_in;

   logic        accept;
   logic [16:0] count_inc;
   logic [7:0]  b;

   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign b         = req_chan.payload.in_byte;
   assign count_inc = {1'b0, count_ff} + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      frag_in   = frag_ff;
      tunnel_in = tunnel_ff;
      msgid_in  = msgid_ff;
      size_in   = size_ff;
      rsp_in    = '0;
      rsp_in.byte_value = b;
      case (phase_ff)
         PH_TUNNEL: begin
            rsp_in.byte_role    = ROLE_TUNNEL;
            rsp_in.field_offset = count_ff[4:0];
            tunnel_in           = {tunnel_ff[23:0], b};
            count_in            = count_inc[15:0];
            if (count_inc >= IdentCount) begin
               count_in = '0;
               phase_in = PH_HASH;
            end
         end
         PH_HASH: begin
            rsp_in.byte_role    = ROLE_HASH;
            rsp_in.field_offset = count_ff[4:0];
            count_in            = count_inc[15:0];
            if (count_inc >= HashCount) begin
               count_in = '0;
               phase_in = frag_ff ? PH_MSGID : PH_SIZE;
            end
         end
         PH_MSGID: begin
            rsp_in.byte_role    = ROLE_MSGID;
            rsp_in.field_offset = count_ff[4:0];
            msgid_in            = {msgid_ff[23:0], b};
            count_in            = count_inc[15:0];
            if (count_inc >= IdentCount) begin
               count_in = '0;
               phase_in = PH_SIZE;
            end
         end
         PH_SIZE: begin
            rsp_in.byte_role    = ROLE_SIZE;
            rsp_in.field_offset = count_ff[4:0];
            size_in             = {size_ff[7:0], b};
            count_in            = count_inc[15:0];
            if (count_inc >= SizeCount) begin
               count_in           = '0;
               rsp_in.header_done = 1'b1;
               if (size_in == 16'd0) begin
                  rsp_in.record_done = 1'b1;
                  phase_in           = PH_FLAG;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            rsp_in.byte_role = ROLE_PAYLOAD;
            count_in         = count_inc[15:0];
            if (count_in >= size_ff) begin
               count_in           = '0;
               rsp_in.record_done = 1'b1;
               phase_in           = PH_FLAG;
            end
         end
         default: begin
            rsp_in.byte_role = ROLE_FLAG;
            tunnel_in        = '0;
            msgid_in         = '0;
            size_in          = '0;
            count_in         = '0;
            mode_in          = b[6:5];
            frag_in          = b[3];
            case (b[6:5])
               MODE_TUNNEL: phase_in = PH_TUNNEL;
               MODE_ROUTER: phase_in = PH_HASH;
               MODE_LOCAL:  phase_in = b[3] ? PH_MSGID : PH_SIZE;
               default: begin
                  rsp_in.error_code = ERR_MODE;
                  mode_in           = MODE_LOCAL;
                  frag_in           = 1'b0;
                  phase_in          = PH_FLAG;
               end
            endcase
         end
      endcase

      // end of buffer before the record completes
      if (rsp_in.error_code == ERR_NONE && req_chan.payload.end_of_buffer
          && !rsp_in.record_done) begin
         rsp_in.error_code = ERR_TRUNCATED;
         count_in          = '0;
         phase_in          = PH_FLAG;
      end

      rsp_in.delivery_mode  = mode_in;
      rsp_in.is_fragmented  = frag_in;
      rsp_in.tunnel_ident   = tunnel_in;
      rsp_in.message_ident  = msgid_in;
      rsp_in.payload_length = size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         count_ff     <= '0;
         mode_ff      <= MODE_LOCAL;
         frag_ff      <= 1'b0;
         tunnel_ff    <= '0;
         msgid_ff     <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            mode_ff      <= mode_in;
            frag_ff      <= frag_in;
            tunnel_ff    <= tunnel_in;
            msgid_ff     <= msgid_in;
            size_ff      <= size_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
